@@ rtl/gedf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gedf_pkg;

   localparam int DEF_MAX_TASKS     = 64;
   localparam int DEF_NUM_CPUS      = 4;
   localparam int DEF_DEADLINE_BITS = 32;

   localparam int CMD_W = 2;
   localparam int OUT_W = 3;

   localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN  = 2'd3;

   localparam logic [OUT_W-1:0] OUT_REGISTERED = 3'd0;
   localparam logic [OUT_W-1:0] OUT_STARTED    = 3'd1;
   localparam logic [OUT_W-1:0] OUT_WAITING    = 3'd2;
   localparam logic [OUT_W-1:0] OUT_NEXT       = 3'd3;
   localparam logic [OUT_W-1:0] OUT_CPU_IDLE   = 3'd4;

endpackage

`default_nettype wire

@@ rtl/gedf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gedf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/global_edf_dispatcher.sv @@
// Global earliest-deadline-first dispatcher for a set of CPUs and tasks.
// The request channel (req_) carries one event word: a command, a task id
// and, for a job start, the job's absolute deadline. Every event with a
// known command and an id below MAX_TASKS gives exactly one response word
// on the rsp_ channel; other events are taken and dropped.
// Events are handled one at a time; req_stall stays high while one is at
// work. How long that takes depends on the queue walks: bookkeeping plus
// a walk over the run or wait queue entries on each removal and on each
// insertion, so it grows with the length of each queue touched. The walks
// go through the queue memories, one entry per memory read, and set the
// throughput.
// A finished response sits in an output register; the next event is taken
// and processed while it waits, and only the hand-over of the following
// response holds while rsp_stall is high.
// After reset the task attribute memory is cleared, one entry per cycle,
// through all MAX_TASKS entries; req_stall is high during that pass.
`timescale 1ns / 1ps
`default_nettype none

module global_edf_dispatcher #(
   parameter int MAX_TASKS     = gedf_pkg::DEF_MAX_TASKS,
   parameter int NUM_CPUS      = gedf_pkg::DEF_NUM_CPUS,
   parameter int DEADLINE_BITS = gedf_pkg::DEF_DEADLINE_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [gedf_pkg::CMD_W-1:0]             req_command,
   input  wire logic [$clog2(MAX_TASKS)-1:0]           req_task_id,
   input  wire logic [DEADLINE_BITS-1:0]               req_deadline,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [gedf_pkg::OUT_W-1:0]                  rsp_outcome,
   output logic [$clog2(MAX_TASKS)-1:0]                rsp_moved_task,
   output logic [(NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1)-1:0] rsp_target_cpu,
   output logic                                        rsp_migrated,
   output logic                                        rsp_preempted_valid,
   output logic [$clog2(MAX_TASKS)-1:0]                rsp_preempted_task
);

   import gedf_pkg::*;

   localparam int TASK_W = $clog2(MAX_TASKS);
   localparam int CPU_W  = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int ATTR_W = CPU_W + 2;
   localparam int DL_W   = DEADLINE_BITS;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ATTR, S_PRE_Q, S_PRE_D, S_COMMIT, S_OPS,
      S_Q_ADDR, S_Q_DATA, S_Q_DL, S_NX_Q, S_NX_D, S_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [TASK_W-1:0] t_ff, t_in;
   logic [DL_W-1:0]   d_ff, d_in;
   logic [CPU_W-1:0]  cput_ff, cput_in;
   logic              runt_ff, runt_in, waitt_ff, waitt_in;
   logic [CPU_W-1:0]  dst_ff, dst_in;
   logic              go_ff, go_in, phase_ff, phase_in;
   logic [3:0]        pend_ff, pend_in;
   logic [TASK_W-1:0] key_ff [4];
   logic [TASK_W-1:0] key_in [4];
   logic [DL_W-1:0]   k2d_ff, k2d_in, k3d_ff, k3d_in;
   logic [1:0]        sel_ff, sel_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic              found_ff, found_in;
   logic [TASK_W-1:0] carry_ff, carry_in;
   logic [CNT_W-1:0]  rc_ff, rc_in, wc_ff, wc_in, clr_ff, clr_in;
   logic [NUM_CPUS-1:0] busy_ff, busy_in;

   logic [OUT_W-1:0]  res_out_ff, res_out_in;
   logic [TASK_W-1:0] res_mv_ff, res_mv_in, res_pt_ff, res_pt_in;
   logic [CPU_W-1:0]  res_cpu_ff, res_cpu_in;
   logic              res_mig_ff, res_mig_in, res_pv_ff, res_pv_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_out_ff, rsp_out_in;
   logic [TASK_W-1:0] rsp_mv_ff, rsp_mv_in, rsp_pt_ff, rsp_pt_in;
   logic [CPU_W-1:0]  rsp_cpu_ff, rsp_cpu_in;
   logic              rsp_mig_ff, rsp_mig_in, rsp_pv_ff, rsp_pv_in;

   logic              dl_we;
   logic [TASK_W-1:0] dl_waddr, dl_raddr;
   logic [DL_W-1:0]   dl_wdata, dl_rdata;
   logic              at_we;
   logic [TASK_W-1:0] at_waddr, at_raddr;
   logic [ATTR_W-1:0] at_wdata, at_rdata;
   logic              rq_we, wq_we;
   logic [TASK_W-1:0] rq_waddr, rq_raddr, wq_waddr, wq_raddr;
   logic [TASK_W-1:0] rq_wdata, rq_rdata, wq_wdata, wq_rdata;

   logic              q_we;
   logic [TASK_W-1:0] q_waddr, q_wdata, q_raddr, qrd, qkey;
   logic              q_rd, is_ins, use_rq;
   logic [CNT_W-1:0]  qcnt, i_next, i_prev;
   logic [DL_W-1:0]   qdx;
   logic              any_idle, tid_ok;
   logic [CPU_W-1:0]  low_idle, a_cpu;

   gedf_ram #(.WIDTH(DL_W), .DEPTH(MAX_TASKS)) u_dl_ram (
      .clock(clock), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
      .raddr(dl_raddr), .rdata(dl_rdata)
   );

   gedf_ram #(.WIDTH(ATTR_W), .DEPTH(MAX_TASKS)) u_attr_ram (
      .clock(clock), .we(at_we), .waddr(at_waddr), .wdata(at_wdata),
      .raddr(at_raddr), .rdata(at_rdata)
   );

   gedf_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_run_ram (
      .clock(clock), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
      .raddr(rq_raddr), .rdata(rq_rdata)
   );

   gedf_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_wait_ram (
      .clock(clock), .we(wq_we), .waddr(wq_waddr), .wdata(wq_wdata),
      .raddr(wq_raddr), .rdata(wq_rdata)
   );

   always_comb begin
      any_idle = 1'b0;
      low_idle = '0;
      for (int c = NUM_CPUS - 1; c >= 0; c--) begin
         if (!busy_ff[c]) begin
            any_idle = 1'b1;
            low_idle = CPU_W'(c);
         end
      end
   end

   assign tid_ok = 32'(req_task_id) < MAX_TASKS;
   assign a_cpu  = at_rdata[ATTR_W-1:2];
   assign is_ins = sel_ff[1];
   assign use_rq = (sel_ff == 2'd0) || (sel_ff == 2'd3);
   assign qcnt   = use_rq ? rc_ff : wc_ff;
   assign qrd    = use_rq ? rq_rdata : wq_rdata;
   assign qkey   = key_ff[sel_ff];
   assign qdx    = sel_ff[0] ? k3d_ff : k2d_ff;
   assign i_next = i_ff + CNT_W'(1);
   assign i_prev = i_ff - CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; t_in = t_ff; d_in = d_ff;
      cput_in = cput_ff; runt_in = runt_ff; waitt_in = waitt_ff;
      dst_in = dst_ff; go_in = go_ff; phase_in = phase_ff; pend_in = pend_ff;
      for (int k = 0; k < 4; k++) begin
         key_in[k] = key_ff[k];
      end
      k2d_in = k2d_ff; k3d_in = k3d_ff; sel_in = sel_ff;
      i_in = i_ff; found_in = found_ff; carry_in = carry_ff;
      rc_in = rc_ff; wc_in = wc_ff; clr_in = clr_ff; busy_in = busy_ff;
      res_out_in = res_out_ff; res_mv_in = res_mv_ff; res_pt_in = res_pt_ff;
      res_cpu_in = res_cpu_ff; res_mig_in = res_mig_ff; res_pv_in = res_pv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_out_in = rsp_out_ff; rsp_mv_in = rsp_mv_ff; rsp_pt_in = rsp_pt_ff;
      rsp_cpu_in = rsp_cpu_ff; rsp_mig_in = rsp_mig_ff; rsp_pv_in = rsp_pv_ff;

      dl_we = 1'b0; dl_waddr = t_ff; dl_wdata = d_ff; dl_raddr = '0;
      at_we = 1'b0; at_waddr = t_ff; at_wdata = '0; at_raddr = '0;
      q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0; q_rd = 1'b0;
      rq_raddr = '0; wq_raddr = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            at_we = 1'b1;
            at_waddr = clr_ff[TASK_W-1:0];
            clr_in = clr_ff + CNT_W'(1);
            if (clr_ff == CNT_W'(MAX_TASKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_command != CMD_UNKNOWN && tid_ok) begin
               cmd_in = req_command;
               t_in = req_task_id;
               d_in = req_deadline;
               at_raddr = req_task_id;
               dl_we = req_command == CMD_START;
               dl_waddr = req_task_id;
               dl_wdata = req_deadline;
               phase_in = 1'b0;
               pend_in = '0;
               res_out_in = OUT_REGISTERED;
               res_mv_in = '0; res_pt_in = '0; res_cpu_in = '0;
               res_mig_in = 1'b0; res_pv_in = 1'b0;
               state_in = S_ATTR;
            end
         end
         S_ATTR: begin
            cput_in = a_cpu;
            runt_in = at_rdata[0];
            waitt_in = at_rdata[1];
            state_in = S_OPS;
            unique case (cmd_ff)
               CMD_REGISTER: begin
                  pend_in = {2'b00, at_rdata[1], at_rdata[0]};
                  key_in[0] = t_ff;
                  key_in[1] = t_ff;
                  at_we = 1'b1;
               end
               CMD_START: begin
                  state_in = S_COMMIT;
                  go_in = 1'b1;
                  if (!busy_ff[a_cpu]) begin
                     dst_in = a_cpu;
                  end else if (any_idle) begin
                     dst_in = low_idle;
                  end else if (rc_ff != '0) begin
                     rq_raddr = TASK_W'(rc_ff - CNT_W'(1));
                     state_in = S_PRE_Q;
                  end else begin
                     go_in = 1'b0;
                  end
               end
               CMD_COMPLETE: begin
                  if (at_rdata[1]) begin
                     pend_in[1] = 1'b1;
                     key_in[1] = t_ff;
                     at_we = 1'b1;
                     at_wdata = {a_cpu, 1'b0, at_rdata[0]};
                  end else if (at_rdata[0]) begin
                     pend_in[0] = 1'b1;
                     key_in[0] = t_ff;
                     at_we = 1'b1;
                     at_wdata = {a_cpu, 2'b00};
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PRE_Q: begin
            key_in[0] = rq_rdata;
            dl_raddr = rq_rdata;
            at_raddr = rq_rdata;
            state_in = S_PRE_D;
         end
         S_PRE_D: begin
            state_in = S_COMMIT;
            if (dl_rdata > d_ff) begin
               pend_in[0] = 1'b1;
               if (!at_rdata[1]) begin
                  pend_in[2] = 1'b1;
                  key_in[2] = key_ff[0];
                  k2d_in = dl_rdata;
               end
               at_we = 1'b1;
               at_waddr = key_ff[0];
               at_wdata = {a_cpu, 2'b10};
               dst_in = a_cpu;
               go_in = 1'b1;
               res_pv_in = 1'b1;
               res_pt_in = key_ff[0];
            end else begin
               go_in = 1'b0;
            end
         end
         S_COMMIT: begin
            at_we = 1'b1;
            state_in = S_OPS;
            if (go_ff) begin
               busy_in[dst_ff] = 1'b1;
               if (!runt_ff) begin
                  pend_in[3] = 1'b1;
                  key_in[3] = t_ff;
                  k3d_in = d_ff;
               end
               at_wdata = {dst_ff, waitt_ff, 1'b1};
               res_out_in = OUT_STARTED;
               res_mv_in = t_ff;
               res_cpu_in = dst_ff;
               res_mig_in = cput_ff != dst_ff;
            end else begin
               if (!waitt_ff) begin
                  pend_in[2] = 1'b1;
                  key_in[2] = t_ff;
                  k2d_in = d_ff;
               end
               at_wdata = {cput_ff, 1'b1, runt_ff};
               res_out_in = OUT_WAITING;
            end
         end
         S_OPS: begin
            if (pend_ff == '0) begin
               state_in = S_RESP;
               if (cmd_ff == CMD_COMPLETE && !phase_ff) begin
                  phase_in = 1'b1;
                  if (wc_ff != '0) begin
                     state_in = S_NX_Q;
                  end else begin
                     busy_in[cput_ff] = 1'b0;
                     res_out_in = OUT_CPU_IDLE;
                     res_cpu_in = cput_ff;
                  end
               end
            end else begin
               sel_in = pend_ff[0] ? 2'd0 : pend_ff[1] ? 2'd1 : pend_ff[2] ? 2'd2 : 2'd3;
               i_in = '0;
               found_in = 1'b0;
               state_in = S_Q_ADDR;
            end
         end
         S_Q_ADDR: begin
            if (i_ff == qcnt) begin
               if (is_ins) begin
                  q_we = 1'b1;
                  q_waddr = qcnt[TASK_W-1:0];
                  q_wdata = found_ff ? carry_ff : qkey;
                  if (use_rq) rc_in = rc_ff + CNT_W'(1);
                  else wc_in = wc_ff + CNT_W'(1);
               end else if (found_ff) begin
                  if (use_rq) rc_in = rc_ff - CNT_W'(1);
                  else wc_in = wc_ff - CNT_W'(1);
               end
               pend_in[sel_ff] = 1'b0;
               state_in = S_OPS;
            end else begin
               q_rd = 1'b1;
               q_raddr = i_ff[TASK_W-1:0];
               state_in = S_Q_DATA;
            end
         end
         S_Q_DATA: begin
            state_in = S_Q_ADDR;
            if (is_ins) begin
               if (found_ff) begin
                  q_we = 1'b1;
                  q_waddr = i_ff[TASK_W-1:0];
                  q_wdata = carry_ff;
                  carry_in = qrd;
                  i_in = i_next;
               end else begin
                  dl_raddr = qrd;
                  carry_in = qrd;
                  state_in = S_Q_DL;
               end
            end else begin
               if (found_ff) begin
                  q_we = 1'b1;
                  q_waddr = i_prev[TASK_W-1:0];
                  q_wdata = qrd;
               end else if (qrd == qkey) begin
                  found_in = 1'b1;
               end
               i_in = i_next;
            end
         end
         S_Q_DL: begin
            if (qdx < dl_rdata) begin
               found_in = 1'b1;
               q_we = 1'b1;
               q_waddr = i_ff[TASK_W-1:0];
               q_wdata = qkey;
            end
            i_in = i_next;
            state_in = S_Q_ADDR;
         end
         S_NX_Q: begin
            key_in[1] = wq_rdata;
            dl_raddr = wq_rdata;
            at_raddr = wq_rdata;
            state_in = S_NX_D;
         end
         S_NX_D: begin
            pend_in[1] = 1'b1;
            if (!at_rdata[0]) begin
               pend_in[3] = 1'b1;
               key_in[3] = key_ff[1];
               k3d_in = dl_rdata;
            end
            at_we = 1'b1;
            at_waddr = key_ff[1];
            at_wdata = {cput_ff, 2'b01};
            res_out_in = OUT_NEXT;
            res_mv_in = key_ff[1];
            res_cpu_in = cput_ff;
            res_mig_in = a_cpu != cput_ff;
            state_in = S_OPS;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_out_in = res_out_ff;
               rsp_mv_in = res_mv_ff;
               rsp_cpu_in = res_cpu_ff;
               rsp_mig_in = res_mig_ff;
               rsp_pv_in = res_pv_ff;
               rsp_pt_in = res_pt_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rq_we = q_we && use_rq;
      wq_we = q_we && !use_rq;
      rq_waddr = q_waddr;
      wq_waddr = q_waddr;
      rq_wdata = q_wdata;
      wq_wdata = q_wdata;
      if (q_rd) begin
         rq_raddr = q_raddr;
         wq_raddr = q_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rc_ff <= '0;
         wc_ff <= '0;
         busy_ff <= '0;
         pend_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rc_ff <= rc_in;
         wc_ff <= wc_in;
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; t_ff <= t_in; d_ff <= d_in;
      cput_ff <= cput_in; runt_ff <= runt_in; waitt_ff <= waitt_in;
      dst_ff <= dst_in; go_ff <= go_in; phase_ff <= phase_in;
      for (int k = 0; k < 4; k++) begin
         key_ff[k] <= key_in[k];
      end
      k2d_ff <= k2d_in; k3d_ff <= k3d_in; sel_ff <= sel_in;
      i_ff <= i_in; found_ff <= found_in; carry_ff <= carry_in;
      res_out_ff <= res_out_in; res_mv_ff <= res_mv_in; res_pt_ff <= res_pt_in;
      res_cpu_ff <= res_cpu_in; res_mig_ff <= res_mig_in; res_pv_ff <= res_pv_in;
      rsp_out_ff <= rsp_out_in; rsp_mv_ff <= rsp_mv_in; rsp_pt_ff <= rsp_pt_in;
      rsp_cpu_ff <= rsp_cpu_in; rsp_mig_ff <= rsp_mig_in; rsp_pv_ff <= rsp_pv_in;
   end

   assign req_stall           = state_ff != S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = rsp_out_ff;
   assign rsp_moved_task      = rsp_mv_ff;
   assign rsp_target_cpu      = rsp_cpu_ff;
   assign rsp_migrated        = rsp_mig_ff;
   assign rsp_preempted_valid = rsp_pv_ff;
   assign rsp_preempted_task  = rsp_pt_ff;

`ifndef SYNTHESIS
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(rc_ff) <= MAX_TASKS && 32'(wc_ff) <= MAX_TASKS)
      else $error("queue count above capacity");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_Q_ADDR |-> i_ff <= qcnt)
      else $error("queue walk past the fill level");

   a_preempt_only_on_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_preempted_valid |-> rsp_outcome == OUT_STARTED)
      else $error("preemption reported without a start");

   a_resp_from_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP && (!rsp_valid_ff || !rsp_stall) |=> rsp_valid && state_ff == S_IDLE)
      else $error("response not handed over");
`endif

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import gedf_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] outcome;
      logic [5:0]       moved_task;
      logic [1:0]       target_cpu;
      logic             migrated;
      logic             preempted_valid;
      logic [5:0]       preempted_task;
   } dispatch_word_type;

   class edf_scoreboard;
      logic [31:0]       deadline_of [64];
      logic [1:0]        home_cpu [64];
      logic [1:0]        membership [64];
      logic              cpu_busy [4];
      int                running_tasks [$];
      int                waiting_tasks [$];
      dispatch_word_type expected_words [$];
      int                errors;

      function new();
         for (int i = 0; i < 64; i++) begin
            deadline_of[i] = '0;
            home_cpu[i] = '0;
            membership[i] = '0;
         end
         for (int c = 0; c < 4; c++) cpu_busy[c] = 1'b0;
         errors = 0;
      endfunction

      function void sorted_insert(ref int lst[$], input int t);
         int i;
         i = 0;
         while (i < lst.size() && !(deadline_of[t] < deadline_of[lst[i]])) i++;
         lst.insert(i, t);
      endfunction

      function void list_remove(ref int lst[$], input int t);
         for (int i = 0; i < lst.size(); i++) begin
            if (lst[i] == t) begin
               lst.delete(i);
               return;
            end
         end
      endfunction

      function void run_add(int t);
         if (membership[t][0]) return;
         sorted_insert(running_tasks, t);
         membership[t][0] = 1'b1;
      endfunction

      function void wait_add(int t);
         if (membership[t][1]) return;
         sorted_insert(waiting_tasks, t);
         membership[t][1] = 1'b1;
      endfunction

      function void run_del(int t);
         if (!membership[t][0]) return;
         list_remove(running_tasks, t);
         membership[t][0] = 1'b0;
      endfunction

      function void wait_del(int t);
         if (!membership[t][1]) return;
         list_remove(waiting_tasks, t);
         membership[t][1] = 1'b0;
      endfunction

      function void note_event(logic [CMD_W-1:0] cmd, logic [5:0] id, logic [31:0] dl);
         dispatch_word_type w;
         int t, dst, p, n, home;
         bit placed;
         w = '0;
         t = id;
         dst = 0;
         placed = 0;
         if (cmd == CMD_UNKNOWN) return;
         if (cmd == CMD_REGISTER) begin
            run_del(t);
            wait_del(t);
            home_cpu[t] = '0;
            w.outcome = OUT_REGISTERED;
         end else if (cmd == CMD_START) begin
            deadline_of[t] = dl;
            if (!cpu_busy[home_cpu[t]]) begin
               dst = home_cpu[t];
               placed = 1;
            end else begin
               for (int c = 0; c < 4 && !placed; c++) begin
                  if (!cpu_busy[c]) begin
                     dst = c;
                     placed = 1;
                  end
               end
               if (!placed && running_tasks.size() > 0) begin
                  p = running_tasks[running_tasks.size() - 1];
                  if (deadline_of[p] > deadline_of[t]) begin
                     run_del(p);
                     wait_add(p);
                     dst = home_cpu[p];
                     placed = 1;
                     w.preempted_valid = 1'b1;
                     w.preempted_task = 6'(p);
                  end
               end
            end
            if (placed) begin
               cpu_busy[dst] = 1'b1;
               run_add(t);
               w.outcome = OUT_STARTED;
               w.moved_task = 6'(t);
               w.target_cpu = 2'(dst);
               w.migrated = (home_cpu[t] != 2'(dst));
               home_cpu[t] = 2'(dst);
            end else begin
               wait_add(t);
               w.outcome = OUT_WAITING;
            end
         end else begin
            home = home_cpu[t];
            if (membership[t][1]) wait_del(t);
            else run_del(t);
            if (waiting_tasks.size() > 0) begin
               n = waiting_tasks[0];
               wait_del(n);
               run_add(n);
               w.outcome = OUT_NEXT;
               w.moved_task = 6'(n);
               w.target_cpu = 2'(home);
               w.migrated = (home_cpu[n] != 2'(home));
               home_cpu[n] = 2'(home);
            end else begin
               cpu_busy[home] = 1'b0;
               w.outcome = OUT_CPU_IDLE;
               w.target_cpu = 2'(home);
            end
         end
         expected_words.push_back(w);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(dispatch_word_type got);
         dispatch_word_type exp;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word %p", got));
            return;
         end
         exp = expected_words.pop_front();
         if (got.outcome != exp.outcome ||
             got.moved_task != exp.moved_task ||
             got.target_cpu != exp.target_cpu ||
             got.migrated != exp.migrated ||
             got.preempted_valid != exp.preempted_valid ||
             got.preempted_task != exp.preempted_task)
            report($sformatf("got %p expected %p", got, exp));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [CMD_W-1:0] req_command = CMD_REGISTER;
   logic [5:0] req_task_id = '0;
   logic [31:0] req_deadline = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_W-1:0] rsp_outcome;
   logic [5:0] rsp_moved_task;
   logic [1:0] rsp_target_cpu;
   logic rsp_migrated;
   logic rsp_preempted_valid;
   logic [5:0] rsp_preempted_task;

   edf_scoreboard sb = new();
   int burst_left = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   global_edf_dispatcher DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_task_id(req_task_id),
      .req_deadline(req_deadline),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_outcome(rsp_outcome), .rsp_moved_task(rsp_moved_task),
      .rsp_target_cpu(rsp_target_cpu), .rsp_migrated(rsp_migrated),
      .rsp_preempted_valid(rsp_preempted_valid),
      .rsp_preempted_task(rsp_preempted_task)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task send_event(logic [CMD_W-1:0] cmd, logic [5:0] id, logic [31:0] dl);
      int gap;
      req_command <= cmd;
      req_task_id <= id;
      req_deadline <= dl;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_event(cmd, id, dl);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
   endtask

   function logic [31:0] pick_deadline();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   task random_event();
      int t, k;
      int busy_ones [$];
      if ($urandom_range(0, 9) == 0) begin
         send_event(CMD_W'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), $urandom);
         return;
      end
      for (int i = 0; i < 64; i++) if (sb.membership[i] != 0) busy_ones.push_back(i);
      k = $urandom_range(0, 19);
      if (k < 9 || busy_ones.size() == 0) begin
         t = $urandom_range(0, 11) + (($urandom_range(0, 3) == 0) ? 48 : 0);
         send_event(CMD_START, 6'(t), pick_deadline());
      end else if (k < 18) begin
         t = busy_ones[$urandom_range(0, busy_ones.size() - 1)];
         send_event(CMD_COMPLETE, 6'(t), $urandom);
      end else begin
         send_event(CMD_REGISTER, 6'($urandom_range(0, 63)), $urandom);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_outcome, rsp_moved_task, rsp_target_cpu, rsp_migrated,
                          rsp_preempted_valid, rsp_preempted_task});
      if (stall_phase == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_phase <= $urandom_range(20, 120);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= ($urandom_range(0, 9) < 8);
         default: rsp_stall <= stall_phase[2];
      endcase
   end

   initial begin
      #50_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_event(CMD_REGISTER, 6'd0, 32'h0);
      send_event(CMD_REGISTER, 6'd63, 32'hFFFF_FFFF);
      send_event(CMD_START, 6'd1, 32'd100);
      send_event(CMD_START, 6'd2, 32'd50);
      send_event(CMD_START, 6'd63, 32'hFFFF_FFFF);
      send_event(CMD_START, 6'd4, 32'd200);
      send_event(CMD_START, 6'd5, 32'd10);
      send_event(CMD_START, 6'd6, 32'hFFFF_FFFF);
      send_event(CMD_START, 6'd7, 32'd10);
      send_event(CMD_START, 6'd0, 32'h0);
      send_event(CMD_START, 6'd6, 32'd5);
      send_event(CMD_COMPLETE, 6'd1, 32'h0);
      send_event(CMD_COMPLETE, 6'd6, 32'h0);
      send_event(CMD_REGISTER, 6'd7, 32'h0);
      send_event(CMD_UNKNOWN, 6'd42, 32'hDEAD_BEEF);
      send_event(CMD_COMPLETE, 6'd33, 32'h0);
      send_event(CMD_COMPLETE, 6'd2, 32'h0);
      send_event(CMD_COMPLETE, 6'd4, 32'h0);
      send_event(CMD_COMPLETE, 6'd5, 32'h0);
      send_event(CMD_COMPLETE, 6'd63, 32'h0);
      send_event(CMD_COMPLETE, 6'd0, 32'h0);
      send_event(CMD_COMPLETE, 6'd12, 32'h0);
      for (int i = 0; i < 1050; i++) random_event();
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (sb.errors == 0 && sb.expected_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
